/* design/oaht_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package oaht_pkg;

    localparam int CMD_W       = 2;
    localparam int HASH_W      = 32;
    localparam int KEY_W       = 32;
    localparam int VALUE_W     = 64;
    localparam int LIMIT_W     = 9;
    localparam int SLOT_ST_W   = 2;

    localparam int SLOTS_DEF      = 256;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 64;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd192;

    typedef logic [CMD_W-1:0]     t_cmd;
    typedef logic [1:0]           t_status;
    typedef logic [SLOT_ST_W-1:0] t_slot_st;

    localparam t_cmd CMD_GET = 2'd0;
    localparam t_cmd CMD_SET = 2'd1;
    localparam t_cmd CMD_DEL = 2'd2;

    localparam t_status RS_DONE      = 2'd0;
    localparam t_status RS_NOT_FOUND = 2'd1;
    localparam t_status RS_FULL      = 2'd2;

    localparam t_slot_st SL_EMPTY = 2'd0;
    localparam t_slot_st SL_TOMB  = 2'd1;
    localparam t_slot_st SL_LIVE  = 2'd2;

    typedef struct packed {
        logic    clr;
        logic    load;
        logic    probe_first;
        logic    probe_step;
        logic    wr;
        logic    wr_tomb;
        logic    inc_used;
        logic    out_load;
        logic    found;
        logic    is_new;
        logic    take_data;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic probe_done;
        logic hit;
        logic have_slot;
        logic slot_tomb;
        logic room;
    } t_dp_stat;

endpackage

`default_nettype wire

/* design/oaht_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module oaht_dp
    import oaht_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_stat                o_stat,
    input  wire logic [KEY_W-1:0]   i_key_id,
    input  wire logic [HASH_W-1:0]  i_key_hash,
    input  wire logic [VALUE_W-1:0] i_value,
    input  wire logic               i_cfg_valid,
    input  wire logic [LIMIT_W-1:0] i_load_limit,
    output logic                    o_found,
    output logic [VALUE_W-1:0]      o_read_value,
    output logic                    o_is_new,
    output t_status                 o_status
);

    localparam int AW   = $clog2(SLOTS);
    localparam int CW   = $clog2(SLOTS + 1);
    localparam int KW   = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int VW   = VALUE_BITS;
    localparam int MW   = SLOT_ST_W + KW + VW;
    localparam int SH   = HASH_W + AW;
    localparam int PW   = 2 * HASH_W + 1;
    localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;

    // floor(2^SH / SLOTS): quotient estimate is exact or one low
    localparam logic [HASH_W:0] RECIP  = (HASH_W + 1)'((64'd1 << SH) / 64'(SLOTS));
    localparam logic [AW:0]     SLOTS_W = (AW + 1)'(SLOTS);
    localparam logic [AW-1:0]   LAST    = AW'(SLOTS - 1);

    logic [MW-1:0]      r_mem [SLOTS];
    logic [MW-1:0]      r_rdata;
    logic [MW-1:0]      wr_data;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic               rd_en;

    logic [KW-1:0]      r_key;
    logic [VW-1:0]      r_val;
    logic [AW:0]        r_hash_lo;
    logic [PW-1:0]      r_prod;
    logic [AW:0]        r_qd;
    logic [AW:0]        q_low;
    logic [AW:0]        qd_low;
    logic [AW:0]        est;
    logic [AW-1:0]      idx0;

    logic [AW-1:0]      r_clr_addr;
    logic [AW-1:0]      r_chk;
    logic [AW-1:0]      r_next;
    logic [AW-1:0]      r_n;
    logic               r_tomb_seen;
    logic [AW-1:0]      r_tomb_at;
    logic               r_hit;
    logic               r_have;
    logic               r_is_tomb;
    logic [AW-1:0]      r_slot;
    logic [VW-1:0]      r_hit_data;
    logic [CW-1:0]      r_used;
    logic [LIMIT_W-1:0] r_limit;

    t_slot_st           rd_st;
    logic [KW-1:0]      rd_key;
    logic [VW-1:0]      rd_data;
    logic               live_hit;
    logic               is_empty;
    logic               is_tomb;
    logic               tomb_now;
    logic               probe_done;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        return (a == LAST) ? '0 : a + AW'(1);
    endfunction

    // start slot: hash mod SLOTS by reciprocal multiply and one correction
    assign q_low  = r_prod[SH +: AW + 1];
    assign qd_low = q_low * SLOTS_W;
    assign est    = r_hash_lo - r_qd;
    assign idx0   = (est >= SLOTS_W) ? AW'(est - SLOTS_W) : est[AW-1:0];

    assign rd_st    = r_rdata[MW-1 -: SLOT_ST_W];
    assign rd_key   = r_rdata[VW +: KW];
    assign rd_data  = r_rdata[VW-1:0];
    assign live_hit = (rd_st == SL_LIVE) && (rd_key == r_key);
    assign is_empty = (rd_st == SL_EMPTY);
    assign is_tomb  = (rd_st == SL_TOMB);
    assign tomb_now = r_tomb_seen || is_tomb;
    assign probe_done = live_hit || is_empty || (r_n == LAST);

    assign rd_en   = i_cmd.probe_first || i_cmd.probe_step;
    assign rd_addr = i_cmd.probe_first ? idx0 : r_next;
    assign wr_addr = i_cmd.clr ? r_clr_addr : r_slot;
    assign wr_data = i_cmd.clr ? {SL_EMPTY, {KW{1'b0}}, {VW{1'b0}}}
                               : {(i_cmd.wr_tomb ? SL_TOMB : SL_LIVE), r_key, r_val};

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr || i_cmd.wr) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_qd <= qd_low;
        if (i_cmd.load) begin
            r_key     <= i_key_id[KW-1:0];
            r_val     <= i_value[VW-1:0];
            r_hash_lo <= i_key_hash[AW:0];
            r_prod    <= PW'(i_key_hash) * PW'(RECIP);
        end
        if (i_cmd.probe_first) begin
            r_chk       <= idx0;
            r_next      <= wrap_inc(idx0);
            r_n         <= '0;
            r_tomb_seen <= 1'b0;
        end else if (i_cmd.probe_step) begin
            r_chk  <= r_next;
            r_next <= wrap_inc(r_next);
            r_n    <= r_n + AW'(1);
            if (is_tomb && !r_tomb_seen) begin
                r_tomb_seen <= 1'b1;
                r_tomb_at   <= r_chk;
            end
            if (probe_done) begin
                r_hit      <= live_hit;
                r_have     <= !live_hit && (is_empty || tomb_now);
                r_is_tomb  <= !live_hit && tomb_now;
                r_slot     <= (!live_hit && r_tomb_seen) ? r_tomb_at : r_chk;
                r_hit_data <= rd_data;
            end
        end
        if (i_cmd.out_load) begin
            o_found      <= i_cmd.found;
            o_is_new     <= i_cmd.is_new;
            o_status     <= i_cmd.status;
            o_read_value <= i_cmd.take_data ? VALUE_W'(r_hit_data) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_used     <= '0;
            r_limit    <= LIMIT_RESET;
        end else begin
            if (i_cmd.clr) begin
                r_clr_addr <= wrap_inc(r_clr_addr);
            end
            if (i_cmd.inc_used) begin
                r_used <= r_used + CW'(1);
            end
            if (i_cfg_valid) begin
                r_limit <= i_load_limit;
            end
        end
    end

    assign o_stat.clr_done   = (r_clr_addr == LAST);
    assign o_stat.probe_done = probe_done;
    assign o_stat.hit        = r_hit;
    assign o_stat.have_slot  = r_have;
    assign o_stat.slot_tomb  = r_is_tomb;
    assign o_stat.room       = CMPW'(r_used) < CMPW'(r_limit);

endmodule

`default_nettype wire

/* design/oaht_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module oaht_ctrl
    import oaht_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_cmd     i_cmd,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_dp_cmd       o_dp_cmd,
    input  wire t_dp_stat i_stat
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_MOD1   = 3'd2;
    localparam logic [2:0] S_MOD2   = 3'd3;
    localparam logic [2:0] S_PROBE  = 3'd4;
    localparam logic [2:0] S_DECIDE = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    t_cmd       r_cmd;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

    always_comb begin
        n_state  = r_state;
        o_dp_cmd = '0;
        o_dp_cmd.status = RS_NOT_FOUND;
        unique case (r_state)
            S_CLEAR: begin
                o_dp_cmd.clr = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_dp_cmd.load = 1'b1;
                    if (i_cmd == CMD_GET || i_cmd == CMD_SET || i_cmd == CMD_DEL) begin
                        n_state = S_MOD1;
                    end else begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_MOD1: begin
                n_state = S_MOD2;
            end
            S_MOD2: begin
                o_dp_cmd.probe_first = 1'b1;
                n_state = S_PROBE;
            end
            S_PROBE: begin
                o_dp_cmd.probe_step = 1'b1;
                if (i_stat.probe_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!r_out_valid || i_ready) begin
                    o_dp_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                    unique case (r_cmd)
                        CMD_GET: begin
                            o_dp_cmd.found     = i_stat.hit;
                            o_dp_cmd.take_data = i_stat.hit;
                            o_dp_cmd.status    = i_stat.hit ? RS_DONE : RS_NOT_FOUND;
                        end
                        CMD_DEL: begin
                            o_dp_cmd.found   = i_stat.hit;
                            o_dp_cmd.wr      = i_stat.hit;
                            o_dp_cmd.wr_tomb = 1'b1;
                            o_dp_cmd.status  = i_stat.hit ? RS_DONE : RS_NOT_FOUND;
                        end
                        CMD_SET: begin
                            priority if (i_stat.hit) begin
                                o_dp_cmd.found  = 1'b1;
                                o_dp_cmd.wr     = 1'b1;
                                o_dp_cmd.status = RS_DONE;
                            end else if (i_stat.have_slot
                                         && (i_stat.slot_tomb || i_stat.room)) begin
                                o_dp_cmd.wr       = 1'b1;
                                o_dp_cmd.is_new   = 1'b1;
                                o_dp_cmd.inc_used = !i_stat.slot_tomb;
                                o_dp_cmd.status   = RS_DONE;
                            end else begin
                                o_dp_cmd.status = RS_FULL;
                            end
                        end
                        default: begin
                            o_dp_cmd.status = RS_NOT_FOUND;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_dp_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd <= i_cmd;
        end
    end

endmodule

`default_nettype wire

/* design/open_addressing_hash_table.sv */
// Key/value table of SLOTS entries with linear probing and tombstones. Each
// request (get, set, delete) starts at key_hash mod SLOTS and walks one slot
// per cycle through the slot memory until it meets the key, an empty slot,
// or has seen every slot; deleted keys leave tombstones, and a new key that
// needs an empty slot is refused with status full once the used count (live
// plus tombstones) reaches load_limit. A get, set or delete forms the start
// slot by a reciprocal multiply, issues the first memory read, walks the
// probe and ends in a decision and write-back step, plus any wait for the
// result to be taken; an unused command code skips the probe and goes
// straight to the decision. After reset the block sweeps every slot of the
// memory empty with o_ready low; load_limit writes are taken at any time
// and should be issued only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module open_addressing_hash_table
    import oaht_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire t_cmd               i_cmd,
    input  wire logic [KEY_W-1:0]   i_key_id,
    input  wire logic [HASH_W-1:0]  i_key_hash,
    input  wire logic [VALUE_W-1:0] i_value,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic                    o_found,
    output logic [VALUE_W-1:0]      o_read_value,
    output logic                    o_is_new,
    output t_status                 o_status,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [LIMIT_W-1:0] i_load_limit
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    oaht_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_cmd    (i_cmd),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_dp_cmd (w_cmd),
        .i_stat   (w_stat)
    );

    oaht_dp #(
        .SLOTS      (SLOTS),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_key_id     (i_key_id),
        .i_key_hash   (i_key_hash),
        .i_value      (i_value),
        .i_cfg_valid  (i_cfg_valid),
        .i_load_limit (i_load_limit),
        .o_found      (o_found),
        .o_read_value (o_read_value),
        .o_is_new     (o_is_new),
        .o_status     (o_status)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request accepted while previous one still in flight");

    a_first_then_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.probe_first |=> w_cmd.probe_step)
        else $error("probe start not followed by probe step");

    a_full_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.out_load && w_cmd.status == RS_FULL) |-> !w_cmd.wr)
        else $error("refused insert wrote the table");

    a_count_on_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.inc_used |-> (w_cmd.wr && w_cmd.is_new && !w_cmd.wr_tomb))
        else $error("used count raised without a new key insert");
`endif

endmodule

`default_nettype wire
